// File: sv/command_frame_parser_top_macros.svh
// Assertion macros shared by the command frame parser checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define COMMAND_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cfp_pkg.sv
// Shared types and constants for the command frame parser.
// No dependencies.
package cfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h56;  // 'V'
  localparam logic [7:0] HDR_SECOND = 8'h53;  // 'S'
  localparam logic [7:0] TYPE_OUT   = 8'h4F;  // 'O'
  localparam logic [7:0] TYPE_IN    = 8'h49;  // 'I'
  localparam logic [7:0] TYPE_SETID = 8'h4D;  // 'M'
  localparam logic [7:0] TYPE_ACK   = 8'h61;  // 'a'

  localparam logic [2:0] K_FRAME = 3'd0;
  localparam logic [2:0] K_TYPE  = 3'd1;
  localparam logic [2:0] K_TRANS = 3'd2;
  localparam logic [2:0] K_HOST  = 3'd3;
  localparam logic [2:0] K_IP    = 3'd4;
  localparam logic [2:0] K_DEV   = 3'd5;
  localparam logic [2:0] K_PAY   = 3'd6;

  localparam logic [1:0] FT_OUT   = 2'd0;
  localparam logic [1:0] FT_IN    = 2'd1;
  localparam logic [1:0] FT_SETID = 2'd2;
  localparam logic [1:0] FT_ACK   = 2'd3;

  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } cfp_item_t;

  // input register contents plus the advance strobe toward the parser
  typedef struct packed {
    logic      fire;
    cfp_item_t item;
  } cfp_step_t;

  typedef struct packed {
    logic [2:0] byte_kind;
    logic [1:0] frame_kind;
    logic [7:0] field_index;
    logic [7:0] field_value;
    logic       frame_done;
  } cfp_result_t;

endpackage

// File: sv/command_frame_parser_top.sv
// Command frame parser: one classified result per received byte.
// An accepted item passes the input register, then the result register, to the out_ ports.
// Throughput: one item per cycle while out_ready is high; the input and result
// registers let a new byte enter while the previous result waits on out_ready.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to idle with frame type output.
module command_frame_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_byte_kind,
  output logic [1:0] out_frame_kind,
  output logic [7:0] out_field_index,
  output logic [7:0] out_field_value,
  output logic       out_frame_done
);
  import cfp_pkg::*;

  cfp_item_t   in_item;
  cfp_step_t   step;
  cfp_result_t result;
  cfp_result_t out_result;
  logic        can_take;

  assign in_item.restart   = in_restart;
  assign in_item.data_byte = in_data_byte;

  cfp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_can_take (can_take),
    .step         (step)
  );

  cfp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .result (result)
  );

  cfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step.fire),
    .result     (result),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_byte_kind   = out_result.byte_kind;
  assign out_frame_kind  = out_result.frame_kind;
  assign out_field_index = out_result.field_index;
  assign out_field_value = out_result.field_value;
  assign out_frame_done  = out_result.frame_done;

endmodule

// File: sv/cfp_in_stage.sv
// Input register of the command frame parser.
// Depends on cfp_pkg.
module cfp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfp_pkg::cfp_item_t in_item,
  input  logic              out_can_take,
  output cfp_pkg::cfp_step_t step
);
  import cfp_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  cfp_item_t item_r;
  logic      advance;
  logic      accept;

  assign advance  = valid_r & out_can_take;
  assign in_ready = ~valid_r | advance;
  assign accept   = in_valid & in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign step.fire = advance;
  assign step.item = item_r;

endmodule

// File: sv/cfp_core.sv
// Frame parser state and per-byte classification logic.
// Depends on cfp_pkg.
module cfp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  cfp_pkg::cfp_step_t  step,
  output cfp_pkg::cfp_result_t result
);
  import cfp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_GOT_V = 4'd1,
    PH_TYPE  = 4'd2,
    PH_TRANS = 4'd3,
    PH_HLEN  = 4'd4,
    PH_HOST  = 4'd5,
    PH_IP    = 4'd6,
    PH_DLEN  = 4'd7,
    PH_DEV   = 4'd8,
    PH_PLEN  = 4'd9,
    PH_PAY   = 4'd10
  } phase_t;

  phase_t     phase_r, phase_nxt, phase_cur;
  logic [7:0] len_r, len_nxt, len_cur;
  logic [7:0] cnt_r, cnt_nxt, cnt_cur;
  logic [1:0] ftype_r, ftype_nxt;
  logic [7:0] cnt_inc;
  logic       field_end;
  logic [7:0] c;
  logic [2:0] kind;
  logic [7:0] index;
  logic       done;

  assign c = step.item.data_byte;

  // restart drops back to idle before the byte is looked at
  assign phase_cur = step.item.restart ? PH_IDLE : phase_r;
  assign len_cur   = step.item.restart ? 8'd0 : len_r;
  assign cnt_cur   = step.item.restart ? 8'd0 : cnt_r;

  assign cnt_inc   = cnt_cur + 8'd1;
  assign field_end = (cnt_inc == len_cur);

  always_comb begin
    phase_nxt = phase_cur;
    len_nxt   = len_cur;
    cnt_nxt   = cnt_cur;
    ftype_nxt = ftype_r;
    kind      = K_FRAME;
    index     = 8'd0;
    done      = 1'b0;
    unique case (phase_cur)
      PH_IDLE: begin
        if (c == HDR_FIRST) begin
          phase_nxt = PH_GOT_V;
        end
      end
      PH_GOT_V: begin
        phase_nxt = (c == HDR_SECOND) ? PH_TYPE : PH_IDLE;
      end
      PH_TYPE: begin
        phase_nxt = PH_TRANS;
        kind      = K_TYPE;
        unique case (c)
          TYPE_OUT:   ftype_nxt = FT_OUT;
          TYPE_IN:    ftype_nxt = FT_IN;
          TYPE_SETID: ftype_nxt = FT_SETID;
          TYPE_ACK:   ftype_nxt = FT_ACK;
          default: begin
            kind      = K_FRAME;
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      PH_TRANS: begin
        kind = K_TRANS;
        if (ftype_r == FT_ACK) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else begin
          phase_nxt = PH_HLEN;
        end
      end
      PH_HLEN: begin
        len_nxt = c;
        cnt_nxt = 8'd0;
        if (c != 8'd0) begin
          phase_nxt = PH_HOST;
        end else begin
          phase_nxt = (ftype_r == FT_SETID) ? PH_DLEN : PH_IP;
        end
      end
      PH_HOST: begin
        kind    = K_HOST;
        index   = cnt_cur;
        cnt_nxt = cnt_inc;
        if (field_end) begin
          cnt_nxt   = 8'd0;
          len_nxt   = 8'd0;
          phase_nxt = (ftype_r == FT_SETID) ? PH_DLEN : PH_IP;
        end
      end
      PH_IP: begin
        kind      = K_IP;
        phase_nxt = PH_PLEN;
      end
      PH_DLEN: begin
        len_nxt   = c;
        cnt_nxt   = 8'd0;
        phase_nxt = (c != 8'd0) ? PH_DEV : PH_PLEN;
      end
      PH_DEV: begin
        kind    = K_DEV;
        index   = cnt_cur;
        cnt_nxt = cnt_inc;
        if (field_end) begin
          cnt_nxt   = 8'd0;
          len_nxt   = 8'd0;
          phase_nxt = PH_PLEN;
        end
      end
      PH_PLEN: begin
        len_nxt = c;
        cnt_nxt = 8'd0;
        if (c != 8'd0) begin
          phase_nxt = PH_PAY;
        end else begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_PAY: begin
        kind    = K_PAY;
        index   = cnt_cur;
        cnt_nxt = cnt_inc;
        if (field_end) begin
          cnt_nxt   = 8'd0;
          len_nxt   = 8'd0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        len_nxt   = 8'd0;
        cnt_nxt   = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      ftype_r <= FT_OUT;
    end else if (step.fire) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      ftype_r <= ftype_nxt;
    end
  end

  assign result.byte_kind   = kind;
  assign result.frame_kind  = ftype_nxt;
  assign result.field_index = index;
  assign result.field_value = c;
  assign result.frame_done  = done;

endmodule

// File: sv/cfp_out_stage.sv
// Result register of the command frame parser.
// Depends on cfp_pkg.
module cfp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cfp_pkg::cfp_result_t result,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cfp_pkg::cfp_result_t out_result
);
  import cfp_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  cfp_result_t result_r;

  assign can_take = ~valid_r | out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// File: sv/cfp_checker.sv
// Port-level checks for the command frame parser, bound to the top level.
// Depends on cfp_pkg and command_frame_parser_top_macros.svh.
`include "command_frame_parser_top_macros.svh"

module cfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_byte_kind,
  input logic [1:0] out_frame_kind,
  input logic [7:0] out_field_index,
  input logic [7:0] out_field_value,
  input logic       out_frame_done
);
  import cfp_pkg::*;

  `CFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte_kind) && $stable(out_frame_kind) && $stable(out_field_index) && $stable(out_field_value) && $stable(out_frame_done), "result changed while stalled")
  `CFP_ASSERT_NOW(a_done_kind, out_valid && out_frame_done, out_byte_kind == K_FRAME || out_byte_kind == K_TRANS || out_byte_kind == K_PAY, "frame end on unexpected byte kind")
  `CFP_ASSERT_NOW(a_index_zero, out_valid && out_byte_kind != K_HOST && out_byte_kind != K_DEV && out_byte_kind != K_PAY, out_field_index == 8'd0, "field index set outside a field")
  `CFP_ASSERT_NOW(a_ack_done, out_valid && out_byte_kind == K_TRANS, out_frame_done == (out_frame_kind == FT_ACK), "transaction byte end flag disagrees with frame type")

endmodule

bind command_frame_parser_top cfp_checker u_cfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte_kind   (out_byte_kind),
  .out_frame_kind  (out_frame_kind),
  .out_field_index (out_field_index),
  .out_field_value (out_field_value),
  .out_frame_done  (out_frame_done)
);
